// ===== rtl/core/pfu_pkg.sv =====
// Shared types, codes, tables and saturation helpers of the particle frame update.
package pfu_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_NOW_TIME   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME = 2'd1;

	// Particle kind codes.
	localparam logic [3:0] KIND_STATIC   = 4'd0;
	localparam logic [3:0] KIND_GRAV     = 4'd1;
	localparam logic [3:0] KIND_SLOWGRAV = 4'd2;
	localparam logic [3:0] KIND_FIRE     = 4'd3;
	localparam logic [3:0] KIND_EXPLODE  = 4'd4;
	localparam logic [3:0] KIND_EXPLODE2 = 4'd5;
	localparam logic [3:0] KIND_BLOB     = 4'd6;
	localparam logic [3:0] KIND_BLOB2    = 4'd7;
	localparam logic [3:0] KIND_RAIL     = 4'd8;

	// Ramp end points in Q4.12.
	localparam logic [15:0] RAMP_SIX   = 16'd24576;
	localparam logic [15:0] RAMP_EIGHT = 16'd32768;

	// Reciprocal of three in Q0.11, exact for floors of values below 768.
	localparam logic [9:0] RECIP3 = 10'd683;

	// How the velocity of one axis is scaled.
	typedef enum logic [1:0] {
		DV_NONE,
		DV_ADD4,
		DV_SUB1,
		DV_SUB4
	} dv_mode_t;

	// Per-axis operation chosen from the kind.
	typedef struct packed {
		dv_mode_t           dv;
		logic signed [23:0] grav;
	} axis_op_t;

	// Stage enables of the pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
		if (x > 40'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -40'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return x[31:0];
		end
	endfunction

	// Palette ramp of the first explosion kind.
	function automatic logic [7:0] ramp1_color(input logic [2:0] idx);
		case (idx)
			3'd0: return 8'h6f;
			3'd1: return 8'h6d;
			3'd2: return 8'h6b;
			3'd3: return 8'h69;
			3'd4: return 8'h67;
			3'd5: return 8'h65;
			3'd6: return 8'h63;
			default: return 8'h61;
		endcase
	endfunction

	// Palette ramp of the second explosion kind.
	function automatic logic [7:0] ramp2_color(input logic [2:0] idx);
		case (idx)
			3'd0: return 8'h6f;
			3'd1: return 8'h6e;
			3'd2: return 8'h6d;
			3'd3: return 8'h6c;
			3'd4: return 8'h6b;
			3'd5: return 8'h6a;
			3'd6: return 8'h68;
			default: return 8'h66;
		endcase
	endfunction

	// Palette ramp of fire.
	function automatic logic [7:0] ramp3_color(input logic [2:0] idx);
		case (idx)
			3'd0: return 8'h6d;
			3'd1: return 8'h6b;
			3'd2: return 8'h06;
			3'd3: return 8'h05;
			3'd4: return 8'h04;
			3'd5: return 8'h03;
			default: return 8'h00;
		endcase
	endfunction

endpackage

// ===== rtl/core/pfu_cfg.sv =====
// Configuration registers: current time and frame time.
module pfu_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pfu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	output logic [31:0]                    now_time,
	output logic [15:0]                    frame_time
);

	logic [31:0] now_time_q;
	logic [15:0] frame_time_q;

	// Writes are taken in every cycle.
	assign cfg_ready = 1'b1;

	// Register file; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_time_q   <= 32'd0;
			frame_time_q <= 16'd0;
		end else if (cfg_valid) begin
			if (cfg_index == pfu_pkg::CFG_NOW_TIME) begin
				now_time_q <= cfg_data;
			end else if (cfg_index == pfu_pkg::CFG_FRAME_TIME) begin
				frame_time_q <= cfg_data[15:0];
			end
		end
	end

	assign now_time   = now_time_q;
	assign frame_time = frame_time_q;

endmodule

// ===== rtl/core/pfu_axis.sv =====
// One axis lane: position advance, velocity scaling and gravity over four stages.
module pfu_axis (
	input  logic                 clk,
	input  pfu_pkg::stage_en_t   en,
	input  logic [15:0]          ft,
	input  logic signed [31:0]   pos,
	input  logic signed [31:0]   vel,
	input  pfu_pkg::axis_op_t    op,
	output logic signed [31:0]   new_pos,
	output logic signed [31:0]   new_vel
);

	logic signed [31:0] pos_s1, vel_s1;
	logic signed [48:0] prod_s1;
	pfu_pkg::axis_op_t  op_s1;

	logic signed [31:0] pos_s2, vel_s2;
	logic signed [35:0] dv_s2;
	logic signed [23:0] grav_s2;

	logic signed [31:0] pos_s3, vel_s3;
	logic signed [23:0] grav_s3;

	logic signed [31:0] pos_s4, vel_s4;

	logic signed [48:0] rnd1_arg;
	logic signed [50:0] rnd4_arg;
	logic signed [32:0] r1;
	logic signed [34:0] r4;
	logic signed [35:0] dv;

	// Stage 1: velocity times frame time, formed exactly.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			pos_s1  <= pos;
			vel_s1  <= vel;
			prod_s1 <= vel * $signed({1'b0, ft});
			op_s1   <= op;
		end
	end

	// Rounded quotients by 2^16, halves toward plus infinity.
	always_comb begin
		rnd1_arg = prod_s1 + 49'sd32768;
		rnd4_arg = {prod_s1, 2'b00} + 51'sd32768;
		r1       = rnd1_arg[48:16];
		r4       = rnd4_arg[50:16];
		case (op_s1.dv)
			pfu_pkg::DV_ADD4: dv = {r4[34], r4};
			pfu_pkg::DV_SUB1: dv = -{{3{r1[32]}}, r1};
			pfu_pkg::DV_SUB4: dv = -{r4[34], r4};
			default:          dv = 36'sd0;
		endcase
	end

	// Stage 2: new position and velocity change.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			pos_s2  <= pfu_pkg::sat32({{8{pos_s1[31]}}, pos_s1} + {{7{r1[32]}}, r1});
			vel_s2  <= vel_s1;
			dv_s2   <= dv;
			grav_s2 <= op_s1.grav;
		end
	end

	// Stage 3: scaled velocity.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			pos_s3  <= pos_s2;
			vel_s3  <= pfu_pkg::sat32({{8{vel_s2[31]}}, vel_s2} + {{4{dv_s2[35]}}, dv_s2});
			grav_s3 <= grav_s2;
		end
	end

	// Stage 4: gravity on the velocity.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			pos_s4 <= pos_s3;
			vel_s4 <= pfu_pkg::sat32({{8{vel_s3[31]}}, vel_s3} + {{16{grav_s3[23]}}, grav_s3});
		end
	end

	assign new_pos = pos_s4;
	assign new_vel = vel_s4;

endmodule

// ===== rtl/core/pfu_attr.sv =====
// Attribute lane: expiry test, ramp phase, palette color and opacity over four stages.
module pfu_attr (
	input  logic               clk,
	input  pfu_pkg::stage_en_t en,
	input  logic [31:0]        now_time,
	input  logic [15:0]        ft,
	input  logic [15:0]        ramp_in,
	input  logic [7:0]         color_in,
	input  logic [3:0]         kind,
	input  logic [31:0]        die_time,
	output logic               alive,
	output logic [15:0]        ramp_out,
	output logic [7:0]         color_out,
	output logic [7:0]         alpha,
	output logic [3:0]         kind_out,
	output logic               expire_next
);

	localparam logic [9:0] RECIP3_W = pfu_pkg::RECIP3;

	logic        alive_s1, fire_s1, past_six_s1;
	logic [3:0]  kind_s1;
	logic [7:0]  color_s1;
	logic [15:0] ramp_s1, step_s1;
	logic [22:0] anum_s1;

	logic        alive_s2;
	logic [3:0]  kind_s2;
	logic [7:0]  color_s2, alpha_s2;
	logic [15:0] ramp_s2;

	logic        alive_s3, expire_s3;
	logic [3:0]  kind_s3;
	logic [7:0]  color_s3, alpha_s3;
	logic [15:0] ramp_s3;

	logic        alive_s4, expire_s4;
	logic [3:0]  kind_s4;
	logic [7:0]  color_s4, alpha_s4;
	logic [15:0] ramp_s4;

	logic [19:0] step_wide;
	logic [14:0] diff;
	logic [16:0] ramp_sum;
	logic [19:0] q3;
	logic        over;
	logic [7:0]  color_sel;

	// Ramp step of the kind and the opacity numerator 255 * (6.0 - ramp).
	always_comb begin
		if (kind == pfu_pkg::KIND_FIRE) begin
			step_wide = {2'b00, ft, 2'b00} + {4'd0, ft} + 20'd8;
		end else if (kind == pfu_pkg::KIND_EXPLODE) begin
			step_wide = {1'b0, ft, 3'b000} + {3'd0, ft, 1'b0} + 20'd8;
		end else if (kind == pfu_pkg::KIND_EXPLODE2) begin
			step_wide = {ft, 4'b0000} - {4'd0, ft} + 20'd8;
		end else begin
			step_wide = 20'd0;
		end
		diff = 15'(pfu_pkg::RAMP_SIX - ramp_in);
	end

	// Stage 1: expiry compare and inputs.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			alive_s1    <= !(die_time < now_time);
			kind_s1     <= kind;
			color_s1    <= color_in;
			ramp_s1     <= ramp_in;
			step_s1     <= step_wide[19:4];
			fire_s1     <= (kind == pfu_pkg::KIND_FIRE);
			past_six_s1 <= (ramp_in >= pfu_pkg::RAMP_SIX);
			anum_s1     <= {diff, 8'd0} - {8'd0, diff};
		end
	end

	// Advanced ramp and floor(numerator / 24576) as a floor by three.
	always_comb begin
		ramp_sum = {1'b0, ramp_s1} + {1'b0, step_s1};
		q3       = anum_s1[22:13] * RECIP3_W;
	end

	// Stage 2: saturated ramp and opacity.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			alive_s2 <= alive_s1;
			kind_s2  <= kind_s1;
			color_s2 <= color_s1;
			ramp_s2  <= ramp_sum[16] ? 16'hffff : ramp_sum[15:0];
			if (!fire_s1) begin
				alpha_s2 <= 8'd255;
			end else if (past_six_s1) begin
				alpha_s2 <= 8'd0;
			end else begin
				alpha_s2 <= q3[18:11];
			end
		end
	end

	// End-of-ramp test and palette lookup.
	always_comb begin
		over      = 1'b0;
		color_sel = color_s2;
		if (kind_s2 == pfu_pkg::KIND_FIRE) begin
			over = (ramp_s2 >= pfu_pkg::RAMP_SIX);
			if (!over) color_sel = pfu_pkg::ramp3_color(ramp_s2[14:12]);
		end else if (kind_s2 == pfu_pkg::KIND_EXPLODE) begin
			over = (ramp_s2 >= pfu_pkg::RAMP_EIGHT);
			if (!over) color_sel = pfu_pkg::ramp1_color(ramp_s2[14:12]);
		end else if (kind_s2 == pfu_pkg::KIND_EXPLODE2) begin
			over = (ramp_s2 >= pfu_pkg::RAMP_EIGHT);
			if (!over) color_sel = pfu_pkg::ramp2_color(ramp_s2[14:12]);
		end
	end

	// Stage 3: expiry flag and color.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			alive_s3  <= alive_s2;
			kind_s3   <= kind_s2;
			color_s3  <= color_sel;
			ramp_s3   <= ramp_s2;
			alpha_s3  <= alpha_s2;
			expire_s3 <= over;
		end
	end

	// Stage 4: result register; a removed particle keeps only its kind.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			alive_s4  <= alive_s3;
			kind_s4   <= kind_s3;
			color_s4  <= alive_s3 ? color_s3 : 8'd0;
			ramp_s4   <= alive_s3 ? ramp_s3 : 16'd0;
			alpha_s4  <= alive_s3 ? alpha_s3 : 8'd0;
			expire_s4 <= alive_s3 & expire_s3;
		end
	end

	assign alive       = alive_s4;
	assign kind_out    = kind_s4;
	assign color_out   = color_s4;
	assign ramp_out    = ramp_s4;
	assign alpha       = alpha_s4;
	assign expire_next = expire_s4;

endmodule

// ===== rtl/core/particle_frame_update.sv =====
// Top level of the particle frame update pipeline.
//
// Usage: write now_time (index 0) and frame_time (index 1) through the
// configuration channel while no particle is in flight, then stream one
// particle per transaction on the input channel. Every input transaction
// gives exactly one result transaction on the output channel, in order.
//
// The result passes through the four register stages (multiply, round and
// add, velocity scale, gravity) before out_valid rises. One particle is
// taken in every cycle while the output is not stalled; each stage holds
// one particle, with one 32x17 multiplier per axis.
//
// Each stage advances when it is empty or the stage after it advances, so
// a stalled receiver holds the result in the last stage while earlier
// stages keep filling; in_ready drops only once all four stages are full.
// Nothing is lost or repeated across a stall.
//
// Reset clears the stage valid bits and both configuration registers to
// zero. Configuration writes are accepted in every cycle.
module particle_frame_update (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pfu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [31:0]             pos_x,
	input  logic signed [31:0]             pos_y,
	input  logic signed [31:0]             pos_z,
	input  logic signed [31:0]             vel_x,
	input  logic signed [31:0]             vel_y,
	input  logic signed [31:0]             vel_z,
	input  logic [15:0]                    ramp_in,
	input  logic [7:0]                     color_in,
	input  logic [3:0]                     kind,
	input  logic [31:0]                    die_time,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           alive,
	output logic signed [31:0]             new_pos_x,
	output logic signed [31:0]             new_pos_y,
	output logic signed [31:0]             new_pos_z,
	output logic signed [31:0]             new_vel_x,
	output logic signed [31:0]             new_vel_y,
	output logic signed [31:0]             new_vel_z,
	output logic [15:0]                    ramp_out,
	output logic [7:0]                     color_out,
	output logic [7:0]                     alpha,
	output logic [3:0]                     kind_out,
	output logic                           expire_next
);

	logic [31:0]        now_time;
	logic [15:0]        frame_time;
	pfu_pkg::stage_en_t en;
	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	pfu_pkg::axis_op_t  op_xy, op_z;
	logic [18:0]        g_w;
	logic [22:0]        g30_w;
	logic signed [31:0] lane_pos_x, lane_pos_y, lane_pos_z;
	logic signed [31:0] lane_vel_x, lane_vel_y, lane_vel_z;

	pfu_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.now_time   (now_time),
		.frame_time (frame_time)
	);

	// Stage enables: a stage moves when it is empty or its successor moves.
	always_comb begin
		en.s4 = !valid_s4 || out_ready;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign in_ready  = en.s1;
	assign out_valid = valid_s4;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= in_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	// Gravity amounts: g = round(2.5 ft), strong gravity = 75 ft.
	always_comb begin
		g_w   = 19'(({3'd0, frame_time} + {1'b0, frame_time, 2'b00} + 19'd1) >> 1);
		g30_w = {1'b0, frame_time, 6'd0} + {4'd0, frame_time, 3'd0}
			+ {6'd0, frame_time, 1'b0} + {7'd0, frame_time};
	end

	// Per-axis operations decoded from the kind.
	always_comb begin
		op_xy.grav = 24'sd0;
		op_z.grav  = 24'sd0;
		op_xy.dv   = pfu_pkg::DV_NONE;
		op_z.dv    = pfu_pkg::DV_NONE;
		if (kind inside {pfu_pkg::KIND_EXPLODE, pfu_pkg::KIND_BLOB}) begin
			op_xy.dv = pfu_pkg::DV_ADD4;
			op_z.dv  = pfu_pkg::DV_ADD4;
		end else if (kind == pfu_pkg::KIND_EXPLODE2) begin
			op_xy.dv = pfu_pkg::DV_SUB1;
			op_z.dv  = pfu_pkg::DV_SUB1;
		end else if (kind == pfu_pkg::KIND_BLOB2) begin
			op_xy.dv = pfu_pkg::DV_SUB4;
		end
		if (kind == pfu_pkg::KIND_FIRE) begin
			op_z.grav = $signed({5'd0, g_w});
		end else if (kind inside {pfu_pkg::KIND_EXPLODE, pfu_pkg::KIND_EXPLODE2}) begin
			op_z.grav = -$signed({1'b0, g30_w});
		end else if (kind inside {pfu_pkg::KIND_GRAV, pfu_pkg::KIND_SLOWGRAV,
				pfu_pkg::KIND_BLOB, pfu_pkg::KIND_BLOB2}) begin
			op_z.grav = -$signed({5'd0, g_w});
		end
	end

	pfu_axis u_axis_x (
		.clk (clk), .en (en), .ft (frame_time), .pos (pos_x), .vel (vel_x),
		.op (op_xy), .new_pos (lane_pos_x), .new_vel (lane_vel_x)
	);

	pfu_axis u_axis_y (
		.clk (clk), .en (en), .ft (frame_time), .pos (pos_y), .vel (vel_y),
		.op (op_xy), .new_pos (lane_pos_y), .new_vel (lane_vel_y)
	);

	pfu_axis u_axis_z (
		.clk (clk), .en (en), .ft (frame_time), .pos (pos_z), .vel (vel_z),
		.op (op_z), .new_pos (lane_pos_z), .new_vel (lane_vel_z)
	);

	pfu_attr u_attr (
		.clk         (clk),
		.en          (en),
		.now_time    (now_time),
		.ft          (frame_time),
		.ramp_in     (ramp_in),
		.color_in    (color_in),
		.kind        (kind),
		.die_time    (die_time),
		.alive       (alive),
		.ramp_out    (ramp_out),
		.color_out   (color_out),
		.alpha       (alpha),
		.kind_out    (kind_out),
		.expire_next (expire_next)
	);

	// A removed particle reports zero motion.
	assign new_pos_x = alive ? lane_pos_x : 32'sd0;
	assign new_pos_y = alive ? lane_pos_y : 32'sd0;
	assign new_pos_z = alive ? lane_pos_z : 32'sd0;
	assign new_vel_x = alive ? lane_vel_x : 32'sd0;
	assign new_vel_y = alive ? lane_vel_y : 32'sd0;
	assign new_vel_z = alive ? lane_vel_z : 32'sd0;

endmodule

// ===== rtl/core/pfu_checker.sv =====
// Port-level checks of the particle frame update and their binding.
module pfu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               alive,
	input logic signed [31:0] new_pos_x,
	input logic signed [31:0] new_vel_z,
	input logic [15:0]        ramp_out,
	input logic [7:0]         color_out,
	input logic [7:0]         alpha,
	input logic [3:0]         kind_out,
	input logic               expire_next
);

	// A stalled result transaction holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_pos_x) && $stable(kind_out)
			&& $stable(ramp_out))
		else $error("stalled result changed");

	// A removed particle reports zeros apart from its kind.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !alive |-> new_pos_x == 32'sd0 && new_vel_z == 32'sd0
			&& ramp_out == 16'd0 && color_out == 8'd0 && alpha == 8'd0 && !expire_next)
		else $error("removed particle has nonzero fields");

	// Only live ramp kinds flag expiry.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expire_next |-> alive && (kind_out == pfu_pkg::KIND_FIRE
			|| kind_out == pfu_pkg::KIND_EXPLODE || kind_out == pfu_pkg::KIND_EXPLODE2))
		else $error("expiry flagged on a kind without a ramp");

	// Only fire is translucent.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alive && kind_out != pfu_pkg::KIND_FIRE |-> alpha == 8'd255)
		else $error("non-fire particle not opaque");

endmodule

bind particle_frame_update pfu_checker u_pfu_checker (.*);
